FILE: rtl/yaz0sd_pkg.sv
package yaz0sd_pkg;

    // History ring default depth
    localparam int HISTORY_DEPTH_DEF = 4096;

    // Item kinds on the input tuser field
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_ADVANCE = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC  = 2'd1;
    localparam logic [1:0] ST_BUSY_COPY  = 2'd2;
    localparam logic [1:0] ST_AFTER_DONE = 2'd3;

    // Stream run state
    localparam logic [1:0] RUN_ACTIVE = 2'd0;
    localparam logic [1:0] RUN_DONE   = 2'd1;
    localparam logic [1:0] RUN_BAD    = 2'd2;

    // Token parser phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_TOKEN  = 3'd1;
    localparam logic [2:0] PH_PAIR2  = 3'd2;
    localparam logic [2:0] PH_PAIR3  = 3'd3;

    // Header layout and copy length biases
    localparam logic [4:0] HDR_LEN_START = 5'd4;
    localparam logic [4:0] HDR_LEN_END   = 5'd8;
    localparam logic [4:0] HDR_SIZE      = 5'd16;
    localparam logic [8:0] SHORT_BIAS    = 9'd2;
    localparam logic [8:0] LONG_BIAS     = 9'h012;

    // Configuration register indexes
    localparam logic CFG_SKIP_COUNT = 1'b0;
    localparam logic CFG_MAX_OUTPUT = 1'b1;

    // One result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       want_advance;
        logic [1:0] status;
    } t_result;

    // Expected magic byte for header positions 0..3
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h59;
            2'd1:    m = 8'h61;
            2'd2:    m = 8'h7A;
            default: m = 8'h30;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/yaz0_stream_decoder_top.sv
// Channel   Dir  Handshake              Payload
// s         in   i_s_tvalid/o_s_tready   tdata[7:0] data_byte, tuser[1:0] kind
// m         out  o_m_tvalid/i_m_tready   tdata[7:0] out_byte, tlast last,
//                                       tuser[0] byte_valid, [1] want_advance,
//                                       [3:2] status
// cfg       in   i_cfg_we                i_cfg_index, i_cfg_data[31:0]
//
// One item per cycle while o_s_tready is high; its result word is registered in the output buffer before it shows on m.
// The rate is set by the history ring: one write and one registered read per
// cycle, the read addressed ahead from the next copy pointer, with write forwarding.
// Reset is synchronous and active low; the ring is not cleared.
// A two-word output buffer holds results under stall; o_s_tready drops only
// when both words are full.
module yaz0_stream_decoder_top
    import yaz0sd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] data_byte
    input  logic [1:0]  i_s_tuser,  // [1:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // [7:0] out_byte
    output logic [3:0]  o_m_tuser,  // [0] byte_valid, [1] want_advance, [3:2] status
    output logic        o_m_tlast
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    logic          acc;
    logic          hist_we;
    logic [AW-1:0] hist_waddr, hist_raddr;
    logic [7:0]    hist_wdata, hist_rdata;
    t_result       result, out_word;

    assign acc = i_s_tvalid && o_s_tready;

    yaz0sd_history #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    yaz0sd_core #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_acc        (acc),
        .i_kind       (i_s_tuser),
        .i_byte       (i_s_tdata),
        .i_hist_rdata (hist_rdata),
        .o_hist_we    (hist_we),
        .o_hist_waddr (hist_waddr),
        .o_hist_wdata (hist_wdata),
        .o_hist_raddr (hist_raddr),
        .o_result     (result)
    );

    yaz0sd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (acc),
        .i_word      (result),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .i_pop_ready (i_m_tready),
        .o_word      (out_word)
    );

    assign o_m_tdata = out_word.out_byte;
    assign o_m_tuser = {out_word.status, out_word.want_advance, out_word.byte_valid};
    assign o_m_tlast = out_word.last;

endmodule

FILE: rtl/yaz0sd_history.sv
module yaz0sd_history
    import yaz0sd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] i_waddr,
    input  logic [7:0]                       i_wdata,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] i_raddr,
    output logic [7:0]                       o_rdata
);

    logic [7:0] r_mem [HISTORY_DEPTH];
    logic [7:0] r_q;
    logic       r_byp;
    logic [7:0] r_byp_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    // Forward a write that lands on the address being read
    always_ff @(posedge i_clk) begin
        r_byp      <= i_we && (i_waddr == i_raddr);
        r_byp_data <= i_wdata;
    end

    assign o_rdata = r_byp ? r_byp_data : r_q;

endmodule

FILE: rtl/yaz0sd_core.sv
module yaz0sd_core
    import yaz0sd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [31:0]                      i_cfg_data,
    input  logic                             i_acc,
    input  logic [1:0]                       i_kind,
    input  logic [7:0]                       i_byte,
    input  logic [7:0]                       i_hist_rdata,
    output logic                             o_hist_we,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_hist_waddr,
    output logic [7:0]                       o_hist_wdata,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_hist_raddr,
    output t_result                          o_result
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    logic [31:0] r_skip, r_max;
    logic [AW-1:0] r_wptr, n_wptr;
    logic [4:0]  r_hidx, n_hidx;
    logic [31:0] r_total, n_total;
    logic [31:0] r_decoded, n_decoded;
    logic [31:0] r_emitted, n_emitted;
    logic [7:0]  r_code, n_code;
    logic [3:0]  r_bits, n_bits;
    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_pair, n_pair;
    logic [8:0]  r_rem, n_rem;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [1:0]  r_run, n_run;

    logic        put_en;
    logic [7:0]  put_val;
    logic [AW:0] back;
    logic [32:0] emit_next;
    logic        reach;
    t_result     res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= '0;
            r_max  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SKIP_COUNT) begin
                r_skip <= i_cfg_data;
            end else begin
                r_max <= i_cfg_data;
            end
        end
    end

    // Copy source for a back-reference, wrapped into the ring
    always_comb begin
        back = {1'b0, r_wptr} - (AW+1)'({r_pair[3:0], i_byte}) - (AW+1)'(1);
        if (back[AW]) begin
            back = back + (AW+1)'(HISTORY_DEPTH);
        end
    end

    // Limit check for the byte about to be emitted
    always_comb begin
        emit_next = {1'b0, r_emitted} + 33'd1;
        reach = ({1'b0, emit_next} + {2'b0, r_skip} >= {2'b0, r_total})
                || ((r_max != '0) && (emit_next >= {1'b0, r_max}));
    end

    // Decode one item
    always_comb begin
        n_wptr    = r_wptr;
        n_hidx    = r_hidx;
        n_total   = r_total;
        n_decoded = r_decoded;
        n_emitted = r_emitted;
        n_code    = r_code;
        n_bits    = r_bits;
        n_phase   = r_phase;
        n_pair    = r_pair;
        n_rem     = r_rem;
        n_rptr    = r_rptr;
        n_run     = r_run;
        put_en    = 1'b0;
        put_val   = i_byte;
        res       = '0;

        if (i_acc && i_kind == KIND_RESTART) begin
            n_wptr    = '0;
            n_hidx    = '0;
            n_total   = '0;
            n_decoded = '0;
            n_emitted = '0;
            n_code    = '0;
            n_bits    = '0;
            n_phase   = PH_HEADER;
            n_pair    = '0;
            n_rem     = '0;
            n_rptr    = '0;
            n_run     = RUN_ACTIVE;
        end else if (i_acc && (i_kind == KIND_BYTE || i_kind == KIND_ADVANCE)) begin
            if (r_run != RUN_ACTIVE) begin
                res.status = (r_run == RUN_BAD) ? ST_BAD_MAGIC : ST_AFTER_DONE;
            end else if (i_kind == KIND_ADVANCE) begin
                if (r_rem != '0) begin
                    put_en  = 1'b1;
                    put_val = i_hist_rdata;
                    n_rptr  = (r_rptr == AW'(HISTORY_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
                    n_rem   = r_rem - 9'd1;
                end
            end else if (r_rem != '0) begin
                res.status = ST_BUSY_COPY;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (r_hidx < HDR_LEN_START && i_byte != magic_byte(r_hidx[1:0])) begin
                            n_run      = RUN_BAD;
                            res.status = ST_BAD_MAGIC;
                        end else begin
                            if (r_hidx >= HDR_LEN_START && r_hidx < HDR_LEN_END) begin
                                n_total = {r_total[23:0], i_byte};
                            end
                            n_hidx = r_hidx + 5'd1;
                            if (r_hidx + 5'd1 >= HDR_SIZE) begin
                                n_phase = PH_TOKEN;
                                n_bits  = '0;
                                if (r_skip >= n_total) begin
                                    n_run = RUN_DONE;
                                end
                            end
                        end
                    end
                    PH_TOKEN: begin
                        if (r_bits == '0) begin
                            n_code = i_byte;
                            n_bits = 4'd8;
                        end else begin
                            n_code = {r_code[6:0], 1'b0};
                            n_bits = r_bits - 4'd1;
                            if (r_code[7]) begin
                                put_en = 1'b1;
                            end else begin
                                n_pair  = i_byte;
                                n_phase = PH_PAIR2;
                            end
                        end
                    end
                    PH_PAIR2: begin
                        n_rptr = back[AW-1:0];
                        if (r_pair[7:4] == 4'd0) begin
                            n_phase = PH_PAIR3;
                        end else begin
                            n_rem   = {5'd0, r_pair[7:4]} + SHORT_BIAS;
                            n_phase = PH_TOKEN;
                        end
                    end
                    PH_PAIR3: begin
                        n_rem   = {1'b0, i_byte} + LONG_BIAS;
                        n_phase = PH_TOKEN;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end

        // Store a decoded byte, emit it once past the skipped part
        if (put_en) begin
            n_wptr = (r_wptr == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            if (r_decoded != '1) begin
                n_decoded = r_decoded + 32'd1;
            end
            if (r_decoded >= r_skip) begin
                res.out_byte   = put_val;
                res.byte_valid = 1'b1;
                n_emitted      = emit_next[31:0];
                if (reach) begin
                    res.last = 1'b1;
                    n_run    = RUN_DONE;
                    n_rem    = '0;
                end
            end
        end

        res.want_advance = (n_run == RUN_ACTIVE) && (n_rem != '0);
    end

    // Stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr    <= '0;
            r_hidx    <= '0;
            r_total   <= '0;
            r_decoded <= '0;
            r_emitted <= '0;
            r_code    <= '0;
            r_bits    <= '0;
            r_phase   <= PH_HEADER;
            r_pair    <= '0;
            r_rem     <= '0;
            r_rptr    <= '0;
            r_run     <= RUN_ACTIVE;
        end else begin
            r_wptr    <= n_wptr;
            r_hidx    <= n_hidx;
            r_total   <= n_total;
            r_decoded <= n_decoded;
            r_emitted <= n_emitted;
            r_code    <= n_code;
            r_bits    <= n_bits;
            r_phase   <= n_phase;
            r_pair    <= n_pair;
            r_rem     <= n_rem;
            r_rptr    <= n_rptr;
            r_run     <= n_run;
        end
    end

    // Ring write of the decoded byte; read the next copy source ahead
    assign o_hist_we    = put_en && i_rst_n;
    assign o_hist_waddr = r_wptr;
    assign o_hist_wdata = put_val;
    assign o_hist_raddr = n_rptr;
    assign o_result     = res;

endmodule

FILE: rtl/yaz0sd_out_buf.sv
module yaz0sd_out_buf
    import yaz0sd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_word,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_pop_ready,
    output t_result o_word
);

    logic    r_main_valid, r_skid_valid;
    t_result r_main, r_skid;
    logic    pop;

    assign pop = r_main_valid && i_pop_ready;

    // Control: main word toward the sink, skid word catches a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_main_valid && !pop) begin
            if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_main_valid <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= i_push;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (r_main_valid && !pop) begin
            if (i_push) begin
                r_skid <= i_word;
            end
        end else if (r_skid_valid) begin
            r_main <= r_skid;
        end else if (i_push) begin
            r_main <= i_word;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_word  = r_main;

endmodule

FILE: rtl/yaz0sd_checker.sv
module yaz0sd_checker
    import yaz0sd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_cfg_index,
    input logic [31:0] i_cfg_data,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic [3:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // Hold a stalled result word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result word changed under stall");

    // Last flag only on an emitted byte
    a_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[0])
        else $error("last without an emitted byte");

    // An emitted byte never carries an error status
    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tuser[3:2] == ST_OK)
        else $error("emitted byte with error status");

    // A new result word follows an accepted item
    a_word_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !$past(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready))
        else $error("result word without an accepted item");

    // Last byte ends the copy request
    a_last_no_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> !o_m_tuser[1])
        else $error("advance requested after last byte");

endmodule

bind yaz0_stream_decoder_top yaz0sd_checker u_checker (.*);
